FILE: src/edit_distance_engine_assert.svh
// Assertion helpers for the edit distance engine.
// Each macro expects clk and arst_n in scope.
`ifndef EDIT_DISTANCE_ENGINE_ASSERT_SVH
`define EDIT_DISTANCE_ENGINE_ASSERT_SVH

// same-cycle implication
`define EDE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define EDE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/ede_pkg.sv
package ede_pkg;

	localparam int MAX_LEN_DEF = 256;

	localparam logic [1:0] KIND_CLEAR  = 2'd0;
	localparam logic [1:0] KIND_APPEND = 2'd1;
	localparam logic [1:0] KIND_QUERY  = 2'd2;
	localparam logic [1:0] KIND_FINISH = 2'd3;

	localparam logic [8:0] DIST_SAT = 9'd511;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] symbol;
	} in_word_t;

	typedef struct packed {
		logic [8:0] distance;
		logic       overflow;
	} out_word_t;

endpackage

FILE: src/ede_cell.sv
// One DP cell: min(left + 1, above + 1, diag + mismatch).
module ede_cell #(
	parameter int W = 9
) (
	input  logic [W-1:0] left,
	input  logic [W-1:0] above,
	input  logic [W-1:0] diag,
	input  logic         match,
	output logic [W-1:0] best
);

	logic [W:0] ins_c;
	logic [W:0] del_c;
	logic [W:0] sub_c;
	logic [W:0] min_c;

	always_comb begin
		ins_c = {1'b0, left} + (W+1)'(1);
		del_c = {1'b0, above} + (W+1)'(1);
		sub_c = {1'b0, diag} + (W+1)'(match ? 1'b0 : 1'b1);
		min_c = ins_c;
		if (del_c < min_c) begin
			min_c = del_c;
		end
		if (sub_c < min_c) begin
			min_c = sub_c;
		end
		// never exceeds MAX_LEN, so the top bit is clear
		best = min_c[W-1:0];
	end

endmodule

FILE: src/edit_distance_engine.sv
// Levenshtein edit distance engine (unit insert, delete and substitute costs). The reference
// string lives in a byte memory and the DP row in a second memory, both with synchronous reads.
// A clear word, an append word and a query word past the length limit are handled in the
// idle state. A query word sweeps the row one cell per cycle through a two-stage
// read/compute-and-write pipeline, so the row memory's single read port and the cell recurrence
// set the rate. With an empty reference a query word only counts up the query length. A finish
// word reads the last row entry and then waits in the result state for the result register to
// drain. The row needs no clearing pass: while the query is empty, row entry j reads as j and
// entry 0 always equals the query length, so re-initialising the row is free. Distances above
// 511 saturate; overflow stays set until the next clear word.
`include "edit_distance_engine_assert.svh"

module edit_distance_engine #(
	parameter int MAX_LEN = ede_pkg::MAX_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ede_pkg::in_word_t in_word,
	output logic              out_valid,
	input  logic              out_ready,
	output ede_pkg::out_word_t out_word
);

	// widths: row values and lengths reach MAX_LEN, reference index stays below it
	localparam int RW = $clog2(MAX_LEN + 1);
	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SWEEP = 3'b010,
		ST_FIN   = 3'b100
	} state_t;

	state_t state_q;

	logic [RW-1:0] ref_len_q;
	logic [RW-1:0] q_len_q;
	logic          ovf_q;

	// sweep issue side
	logic [RW-1:0] j_q;
	logic          issue_on_q;
	logic          issue;
	logic          issue_last;

	// compute/write stage
	logic          valid_s1;
	logic          last_s1;
	logic [RW-1:0] addr_s1;
	logic [7:0]    qsym_q;
	logic [RW-1:0] left_q;
	logic [RW-1:0] diag_q;

	// finish
	logic          fin_mem_q;
	logic [RW-1:0] fin_alt_q;
	logic [RW-1:0] fin_val;
	logic [31:0]   fin_wide;

	// memories
	logic [7:0]    ref_mem [MAX_LEN];
	logic [7:0]    ref_rd_q;
	logic [RW-1:0] row_mem [MAX_LEN + 1];
	logic [RW-1:0] row_rd_q;
	logic          row_rd_en;
	logic [RW-1:0] row_rd_addr;
	logic          row_wr_en;
	logic          ref_wr_en;

	logic          out_valid_q;
	ede_pkg::out_word_t out_word_q;

	logic          in_fire;
	logic          row_fresh;
	logic [RW-1:0] above;
	logic [RW-1:0] best;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// an empty query means the row still holds its initial ramp
	assign row_fresh = (q_len_q == '0);

	assign issue      = (state_q == ST_SWEEP) && issue_on_q;
	assign issue_last = (j_q == ref_len_q - RW'(1));

	assign ref_wr_en = in_fire && (in_word.kind == ede_pkg::KIND_APPEND)
		&& (ref_len_q < RW'(MAX_LEN));
	assign row_wr_en = valid_s1;

	always_comb begin
		row_rd_en   = issue;
		row_rd_addr = j_q + RW'(1);
		if (in_fire && (in_word.kind == ede_pkg::KIND_FINISH)) begin
			row_rd_en   = 1'b1;
			row_rd_addr = ref_len_q;
		end
	end

	// reference byte memory
	always_ff @(posedge clk) begin
		if (ref_wr_en) begin
			ref_mem[ref_len_q[AW-1:0]] <= in_word.symbol;
		end
		if (issue) begin
			ref_rd_q <= ref_mem[j_q[AW-1:0]];
		end
	end

	// DP row memory; reads run ahead of the write, never to the same entry
	always_ff @(posedge clk) begin
		if (row_wr_en) begin
			row_mem[addr_s1] <= best;
		end
		if (row_rd_en) begin
			row_rd_q <= row_mem[row_rd_addr];
		end
	end

	assign above = row_fresh ? addr_s1 : row_rd_q;

	ede_cell #(
		.W(RW)
	) u_cell (
		.left  (left_q),
		.above (above),
		.diag  (diag_q),
		.match (ref_rd_q == qsym_q),
		.best  (best)
	);

	// finish value: empty query gives the reference length, empty reference the query length
	assign fin_val  = fin_mem_q ? row_rd_q : fin_alt_q;
	assign fin_wide = 32'(fin_val);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ref_len_q   <= '0;
			q_len_q     <= '0;
			ovf_q       <= 1'b0;
			issue_on_q  <= 1'b0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// in the result state the load below decides
			if (out_valid_q && out_ready && (state_q != ST_FIN)) begin
				out_valid_q <= 1'b0;
			end
			valid_s1 <= issue;
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						unique case (in_word.kind)
							ede_pkg::KIND_CLEAR: begin
								ref_len_q <= '0;
								q_len_q   <= '0;
								ovf_q     <= 1'b0;
							end
							ede_pkg::KIND_APPEND: begin
								if (ref_len_q < RW'(MAX_LEN)) begin
									ref_len_q <= ref_len_q + RW'(1);
								end else begin
									ovf_q <= 1'b1;
								end
								q_len_q <= '0;
							end
							ede_pkg::KIND_QUERY: begin
								if (q_len_q == RW'(MAX_LEN)) begin
									ovf_q <= 1'b1;
								end else if (ref_len_q == '0) begin
									q_len_q <= q_len_q + RW'(1);
								end else begin
									issue_on_q <= 1'b1;
									state_q    <= ST_SWEEP;
								end
							end
							ede_pkg::KIND_FINISH: begin
								q_len_q <= '0;
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_SWEEP: begin
					if (issue && issue_last) begin
						issue_on_q <= 1'b0;
					end
					if (valid_s1 && last_s1) begin
						q_len_q <= q_len_q + RW'(1);
						state_q <= ST_IDLE;
					end
				end
				ST_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload and pipeline data, no reset
	always_ff @(posedge clk) begin
		if (in_fire && (in_word.kind == ede_pkg::KIND_QUERY)) begin
			j_q    <= '0;
			qsym_q <= in_word.symbol;
			left_q <= q_len_q + RW'(1);   // new entry 0
			diag_q <= q_len_q;            // old entry 0
		end else if (issue) begin
			j_q <= j_q + RW'(1);
		end
		if (issue) begin
			addr_s1 <= j_q + RW'(1);
			last_s1 <= issue_last;
		end
		if (valid_s1) begin
			left_q <= best;
			diag_q <= above;
		end
		if (in_fire && (in_word.kind == ede_pkg::KIND_FINISH)) begin
			fin_mem_q <= (q_len_q != '0) && (ref_len_q != '0);
			fin_alt_q <= (q_len_q == '0) ? ref_len_q : q_len_q;
		end
		if ((state_q == ST_FIN) && (!out_valid_q || out_ready)) begin
			out_word_q.distance <= (fin_wide > 32'(ede_pkg::DIST_SAT)) ? ede_pkg::DIST_SAT
				: fin_wide[8:0];
			out_word_q.overflow <= ovf_q;
		end
	end

	`EDE_ASSERT_IMP(a_wr_in_row, row_wr_en, (addr_s1 != '0) && (addr_s1 <= ref_len_q), "row write outside the reference span")
	`EDE_ASSERT_NXT(a_fin_state, in_fire && (in_word.kind == ede_pkg::KIND_FINISH), state_q == ST_FIN, "finish word did not enter the result state")
	`EDE_ASSERT_IMP(a_s1_in_sweep, valid_s1, state_q == ST_SWEEP, "cell update outside a sweep")
	`EDE_ASSERT_IMP(a_len_bound, 1'b1, (q_len_q <= RW'(MAX_LEN)) && (ref_len_q <= RW'(MAX_LEN)), "length past MAX_LEN")

endmodule
